[src/scf_pkg.sv]
// shared types and constants of the servo command framer
`timescale 1ns / 1ps

package scf_pkg;

   // frame bytes
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] CMD_MOVE  = 8'h01;
   localparam logic [7:0] CMD_STOP  = 8'h02;
   localparam logic [7:0] LEN_MOVE  = 8'd6;
   localparam logic [7:0] LEN_STOP  = 8'd2;

   // clamp limits and reset value of the held angle
   localparam logic [7:0] ANGLE_MAX   = 8'd240;
   localparam logic [9:0] SPEED_MAX   = 10'd1000;
   localparam logic [7:0] ANGLE_RESET = 8'd90;

   // position = angle * 25 / 6, done as a multiply by a scaled reciprocal
   localparam int         POS_SHIFT = 18;
   localparam logic [20:0] POS_MULT = 21'd1092267;

   // byte positions inside a frame
   localparam int          IDX_W      = 4;
   localparam logic [IDX_W-1:0] IDX_SYNC1 = 4'd1;
   localparam logic [IDX_W-1:0] IDX_ID     = 4'd2;
   localparam logic [IDX_W-1:0] IDX_LEN    = 4'd3;
   localparam logic [IDX_W-1:0] IDX_CMD    = 4'd4;
   localparam logic [IDX_W-1:0] IDX_PID    = 4'd5;
   localparam logic [IDX_W-1:0] IDX_POSH   = 4'd6;
   localparam logic [IDX_W-1:0] IDX_POSL   = 4'd7;
   localparam logic [IDX_W-1:0] IDX_SPDH   = 4'd8;
   localparam logic [IDX_W-1:0] IDX_SPDL   = 4'd9;
   localparam logic [IDX_W-1:0] IDX_LAST_MOVE = 4'd10;
   localparam logic [IDX_W-1:0] IDX_LAST_STOP = 4'd6;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_NODE_ID = 1'b0,
      REG_ENABLED = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] node_id;
      logic       enabled;
   } cfg_type;

   // one frame as handed from front to back
   typedef struct packed {
      logic       is_move;
      logic [7:0] node_id;
      logic [9:0] position;
      logic [9:0] speed;
      logic [7:0] held_angle;
      logic [7:0] checksum;
   } frame_type;

endpackage

[src/scf_req_if.sv]
// command channel carrying operation, angle and speed
`timescale 1ns / 1ps

interface scf_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [15:0] angle;
   logic signed [15:0] speed;

   modport source (output valid, operation, angle, speed, input ready);
   modport sink   (input valid, operation, angle, speed, output ready);
endinterface

[src/scf_rsp_if.sv]
// byte channel carrying the framed serial bytes
`timescale 1ns / 1ps

interface scf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;
   logic [7:0] held_angle;

   modport source (output valid, tx_byte, frame_end, held_angle, input ready);
   modport sink   (input valid, tx_byte, frame_end, held_angle, output ready);
endinterface

[src/scf_front.sv]
// front end: clamps a command, computes position and checksum, tracks held angle
`timescale 1ns / 1ps

module scf_front (
   input  logic               clock,
   input  logic               reset,
   input  scf_pkg::cfg_type   cfg,
   input  logic               cmd_valid,
   input  logic               cmd_operation,
   input  logic signed [15:0] cmd_angle,
   input  logic signed [15:0] cmd_speed,
   input  logic               q_full,
   output logic               cmd_ready,
   output logic               q_push,
   output scf_pkg::frame_type q_data
);
   import scf_pkg::*;

   logic [7:0]  held_ff;
   logic [7:0]  held_in;
   logic [7:0]  angle_c;
   logic [9:0]  speed_c;
   logic [28:0] pos_prod;
   logic [9:0]  position;
   logic        is_move;
   logic [7:0]  sum;

   assign cmd_ready = !q_full;
   assign is_move   = !cmd_operation;

   always_comb begin
      if (cmd_angle < 16'sd0) begin
         angle_c = 8'd0;
      end else if (cmd_angle > $signed({8'd0, ANGLE_MAX})) begin
         angle_c = ANGLE_MAX;
      end else begin
         angle_c = cmd_angle[7:0];
      end
      if (cmd_speed < 16'sd0) begin
         speed_c = 10'd0;
      end else if (cmd_speed > $signed({6'd0, SPEED_MAX})) begin
         speed_c = SPEED_MAX;
      end else begin
         speed_c = cmd_speed[9:0];
      end
   end

   assign pos_prod = {21'd0, angle_c} * {8'd0, POS_MULT};
   assign position = pos_prod[POS_SHIFT+9:POS_SHIFT];

   // low byte of the plain sum; inverted below
   always_comb begin
      if (is_move) begin
         sum = cfg.node_id + LEN_MOVE + CMD_MOVE + cfg.node_id
               + {6'd0, position[9:8]} + position[7:0]
               + {6'd0, speed_c[9:8]} + speed_c[7:0];
      end else begin
         sum = cfg.node_id + LEN_STOP + CMD_STOP + cfg.node_id;
      end
   end

   assign held_in = (cmd_valid && cmd_ready && cfg.enabled && is_move) ? angle_c : held_ff;
   assign q_push  = cmd_valid && cmd_ready && cfg.enabled;

   always_comb begin
      q_data.is_move    = is_move;
      q_data.node_id    = cfg.node_id;
      q_data.position   = position;
      q_data.speed      = speed_c;
      q_data.held_angle = held_in;
      q_data.checksum   = ~sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= ANGLE_RESET;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

[src/scf_queue.sv]
// two-entry frame queue between front and back
`timescale 1ns / 1ps

module scf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  scf_pkg::frame_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output scf_pkg::frame_type head
);
   import scf_pkg::*;

   frame_type  entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("frame queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("frame queue read while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("frame queue count lost a write");
`endif

endmodule

[src/scf_back.sv]
// back end: walks the head frame one byte per cycle into the output register, unless out_ready stalls it
`timescale 1ns / 1ps

module scf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  scf_pkg::frame_type head,
   output logic               q_pop,
   input  logic               out_ready,
   output logic               out_valid,
   output logic [7:0]         out_byte,
   output logic               out_end,
   output logic [7:0]         out_held
);
   import scf_pkg::*;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             valid_ff;
   logic             valid_in;
   logic [7:0]       byte_ff;
   logic [7:0]       byte_in;
   logic             end_ff;
   logic             end_in;
   logic [7:0]       held_ff;
   logic             load;
   logic [IDX_W-1:0] last_idx;

   assign last_idx = head.is_move ? IDX_LAST_MOVE : IDX_LAST_STOP;
   assign load     = q_not_empty && (!valid_ff || out_ready);
   assign end_in   = (idx_ff == last_idx);
   assign q_pop    = load && end_in;

   always_comb begin
      case (idx_ff)
         IDX_ID, IDX_PID: byte_in = head.node_id;
         IDX_LEN:         byte_in = head.is_move ? LEN_MOVE : LEN_STOP;
         IDX_CMD:         byte_in = head.is_move ? CMD_MOVE : CMD_STOP;
         IDX_POSH:        byte_in = head.is_move ? {6'd0, head.position[9:8]} : head.checksum;
         IDX_POSL:        byte_in = head.position[7:0];
         IDX_SPDH:        byte_in = {6'd0, head.speed[9:8]};
         IDX_SPDL:        byte_in = head.speed[7:0];
         IDX_LAST_MOVE:   byte_in = head.checksum;
         default:         byte_in = SYNC_BYTE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = end_in ? '0 : idx_ff + 1'b1;
      end
   end

   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         held_ff <= head.held_angle;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_end   = end_ff;
   assign out_held  = held_ff;

`ifndef NO_ASSERTIONS
   a_first_is_sync: assert property (@(posedge clock) disable iff (reset)
      (load && idx_ff == '0) |=> (byte_ff == SYNC_BYTE && !end_ff))
      else $error("frame did not open with a sync byte");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      q_not_empty |-> (idx_ff <= last_idx))
      else $error("byte index ran past the end of the frame");
   a_pop_on_end: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (end_ff && idx_ff == '0))
      else $error("frame released without its checksum byte");
`endif

endmodule

[src/servo_command_framer_unit.sv]
// top level of the servo command framer: csr block, front, frame queue, back
`timescale 1ns / 1ps

// channel  | dir | transaction                          | payload
// req_chan | in  | one move or stop command             | operation, angle, speed
// rsp_chan | out | one byte of a serial frame           | tx_byte, frame_end, held_angle
// csr_*    | in  | apb register write or read          | node_id at 0x0, enabled at 0x4
//
// a move frame leaves as 11 transactions, a stop frame as 7, one byte per cycle from the
// back end's output register while rsp_chan does not stall
// the front is combinational into a two-entry queue that lets it run ahead of the back
// while disabled, commands are taken and dropped with no transaction on rsp_chan
// reset (synchronous, active high) empties the queue and output, held angle goes to 90
// a stall on rsp_chan fills the queue, then drops req_chan ready

module servo_command_framer_unit (
   input  logic                             clock,
   input  logic                             reset,
   scf_req_if.sink                          req_chan,
   scf_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [scf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [scf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [scf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import scf_pkg::*;

   // configuration registers
   logic [7:0]  node_id_ff;
   logic [7:0]  node_id_in;
   logic        enabled_ff;
   logic        enabled_in;
   logic        csr_write;
   csr_reg_type csr_reg;
   cfg_type     cfg;

   // front to queue to back
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_not_empty;
   frame_type   q_data;
   frame_type   q_head;

   // apb: single wait-free access, register picked by the word address bit
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      node_id_in = node_id_ff;
      enabled_in = enabled_ff;
      if (csr_write) begin
         case (csr_reg)
            REG_NODE_ID: node_id_in = csr_pwdata[7:0];
            REG_ENABLED: enabled_in = csr_pwdata[0];
            default:     node_id_in = node_id_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_NODE_ID: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, node_id_ff};
         REG_ENABLED: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, enabled_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= 8'd1;
         enabled_ff <= 1'b0;
      end else begin
         node_id_ff <= node_id_in;
         enabled_ff <= enabled_in;
      end
   end

   assign cfg.node_id = node_id_ff;
   assign cfg.enabled = enabled_ff;

   // front: clamp, position, checksum, held angle
   scf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd_valid     (req_chan.valid),
      .cmd_operation (req_chan.operation),
      .cmd_angle     (req_chan.angle),
      .cmd_speed     (req_chan.speed),
      .q_full        (q_full),
      .cmd_ready     (req_chan.ready),
      .q_push        (q_push),
      .q_data        (q_data)
   );

   // decouples command intake from byte output
   scf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // back: one frame byte per cycle into the output register while rsp_chan does not stall
   scf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .head        (q_head),
      .q_pop       (q_pop),
      .out_ready   (rsp_chan.ready),
      .out_valid   (rsp_chan.valid),
      .out_byte    (rsp_chan.tx_byte),
      .out_end     (rsp_chan.frame_end),
      .out_held    (rsp_chan.held_angle)
   );

`ifndef NO_ASSERTIONS
   a_drop_when_disabled: assert property (@(posedge clock) disable iff (reset)
      q_push |-> enabled_ff)
      else $error("frame queued while disabled");
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && enabled_ff) |-> q_push)
      else $error("accepted command lost before the queue");
   a_id_in_frame: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_data.node_id == node_id_ff))
      else $error("frame carries a stale node id");
`endif

endmodule
